// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Property wrappers for the dlft_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, reset masks the check
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/dlft_pkg.sv =====
// ----------------------------------------------------------------------------
// dlft_pkg
// Types and codes shared by the debug link frame transactor modules.
// ----------------------------------------------------------------------------
package dlft_pkg;

    // request codes on the input channel
    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_SEND  = 3'd1,
        REQ_RECV  = 3'd2,
        REQ_CHECK = 3'd3,
        REQ_HALF  = 3'd4
    } t_req;

    // transaction kind, one-hot
    typedef enum logic [4:0] {
        KIND_IDLE  = 5'b00001,
        KIND_SEND  = 5'b00010,
        KIND_RECV  = 5'b00100,
        KIND_CHECK = 5'b01000,
        KIND_HALF  = 5'b10000
    } t_kind;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_BUS_ERR = 2'd1,
        RES_ILLEGAL = 2'd2,
        RES_NO_CONN = 2'd3
    } t_code;

    localparam logic [7:0] RETRY_RESET = 8'd20;

    // per-tick status handed from the engine to the output register
    typedef struct packed {
        logic  dout;
        logic  busy;
        logic  done;
        t_code code;
    } t_res;

endpackage

// ===== sv/debug_link_frame_transactor_unit.sv =====
// ----------------------------------------------------------------------------
// debug_link_frame_transactor_unit
// Master side of a 17-bit serial debug link, one serial bit tick per transfer.
//
//  channel   direction  handshake                  payload
//  request   in         i_valid / o_ready          req_type, cmd_word, last_word,
//                                                  data_in_bit
//  result    out        o_valid / i_ready          data_out_bit, busy_res, done_res,
//                                                  result_code, rx_word, rx_status
//  config    in         i_cfg_valid / o_cfg_ready  retry_limit
//
//  One tick per cycle unless the result stalls: each accepted tick updates
//  the frame state and loads the result register in the same edge.
//  The next tick is taken whenever the result register is empty or drained
//  in that cycle; a stalled result holds and blocks further ticks.
//  Synchronous active-low reset clears the frame state and sets retry_limit
//  to 20.
// ----------------------------------------------------------------------------
module debug_link_frame_transactor_unit #(
    parameter int WORD_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_req_type,
    input  logic [WORD_BITS-1:0] i_cmd_word,
    input  logic                 i_last_word,
    input  logic                 i_data_in_bit,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_data_out_bit,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [1:0]           o_result_code,
    output logic [WORD_BITS-1:0] o_rx_word,
    output logic                 o_rx_status
);

    logic                 step;
    logic [7:0]           r_retry;
    logic                 r_out_valid;
    dlft_pkg::t_res       r_res;
    logic [WORD_BITS-1:0] r_rx_word;
    logic                 r_rx_status;
    dlft_pkg::t_res       n_res;
    logic [WORD_BITS-1:0] n_rx_word;
    logic                 n_rx_status;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign step        = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry <= dlft_pkg::RETRY_RESET;
        end else if (i_cfg_valid) begin
            r_retry <= i_cfg_data;
        end
    end

    dlft_engine #(
        .WORD_BITS(WORD_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_req_type    (i_req_type),
        .i_cmd_word    (i_cmd_word),
        .i_last_word   (i_last_word),
        .i_data_in_bit (i_data_in_bit),
        .i_retry_limit (r_retry),
        .o_res         (n_res),
        .o_rx_word     (n_rx_word),
        .o_rx_status   (n_rx_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res       <= n_res;
            r_rx_word   <= n_rx_word;
            r_rx_status <= n_rx_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_data_out_bit = r_res.dout;
    assign o_busy_res     = r_res.busy;
    assign o_done_res     = r_res.done;
    assign o_result_code  = r_res.code;
    assign o_rx_word      = r_rx_word;
    assign o_rx_status    = r_rx_status;

endmodule

// ===== sv/dlft_engine.sv =====
// ----------------------------------------------------------------------------
// dlft_engine
// Frame state and next-state logic: advances one serial bit per transfer.
// ----------------------------------------------------------------------------
module dlft_engine #(
    parameter int WORD_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [2:0]           i_req_type,
    input  logic [WORD_BITS-1:0] i_cmd_word,
    input  logic                 i_last_word,
    input  logic                 i_data_in_bit,
    input  logic [7:0]           i_retry_limit,
    output dlft_pkg::t_res       o_res,
    output logic [WORD_BITS-1:0] o_rx_word,
    output logic                 o_rx_status
);

    localparam int PW = $clog2(WORD_BITS + 1);
    localparam logic [WORD_BITS-1:0] REPLY_NOT_READY = '0;
    localparam logic [WORD_BITS-1:0] REPLY_BUS_ERROR = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] REPLY_ILLEGAL   = '1;

    logic [WORD_BITS-1:0] r_tx, n_tx;
    logic [WORD_BITS-1:0] r_rx, n_rx;
    logic [WORD_BITS-1:0] r_frame, n_frame;
    logic [PW-1:0]        r_pos, n_pos;
    logic [7:0]           r_attempts, n_attempts;
    dlft_pkg::t_kind      r_kind, n_kind;
    logic                 r_status, n_status;

    logic                 load;
    logic [WORD_BITS-1:0] rx_shifted;
    dlft_pkg::t_code      err_code;
    logic                 dout;
    logic                 done;
    dlft_pkg::t_code      code;

    assign rx_shifted = {r_rx[WORD_BITS-2:0], i_data_in_bit};

    always_comb begin
        if (rx_shifted == REPLY_BUS_ERROR) begin
            err_code = dlft_pkg::RES_BUS_ERR;
        end else if (rx_shifted == REPLY_ILLEGAL) begin
            err_code = dlft_pkg::RES_ILLEGAL;
        end else begin
            err_code = dlft_pkg::RES_NO_CONN;
        end
    end

    always_comb begin
        n_tx       = r_tx;
        n_rx       = r_rx;
        n_frame    = r_frame;
        n_pos      = r_pos;
        n_attempts = r_attempts;
        n_kind     = r_kind;
        n_status   = r_status;
        load       = 1'b0;
        dout       = 1'b0;
        done       = 1'b0;
        code       = dlft_pkg::RES_OK;
        case (r_kind)
            dlft_pkg::KIND_IDLE: begin
                // latch a request, line stays low
                load = 1'b1;
                case (dlft_pkg::t_req'(i_req_type))
                    dlft_pkg::REQ_SEND: begin
                        n_kind  = dlft_pkg::KIND_SEND;
                        n_frame = i_cmd_word;
                    end
                    dlft_pkg::REQ_RECV: begin
                        n_kind  = dlft_pkg::KIND_RECV;
                        n_frame = i_last_word ? i_cmd_word : '0;
                    end
                    dlft_pkg::REQ_CHECK: begin
                        n_kind  = dlft_pkg::KIND_CHECK;
                        n_frame = i_cmd_word;
                    end
                    dlft_pkg::REQ_HALF: begin
                        n_kind  = dlft_pkg::KIND_HALF;
                        n_frame = i_cmd_word;
                    end
                    default: begin
                        load = 1'b0;
                    end
                endcase
                if (load) begin
                    n_tx       = n_frame;
                    n_pos      = '0;
                    n_attempts = i_retry_limit;
                end
            end
            dlft_pkg::KIND_SEND, dlft_pkg::KIND_RECV,
            dlft_pkg::KIND_CHECK, dlft_pkg::KIND_HALF: begin
                if (r_pos == '0) begin
                    // start bit: sample target status
                    n_status = i_data_in_bit;
                    n_rx     = '0;
                    n_pos    = PW'(1);
                end else begin
                    dout = r_tx[WORD_BITS-1];
                    n_tx = {r_tx[WORD_BITS-2:0], 1'b0};
                    n_rx = rx_shifted;
                    if (r_pos >= PW'(WORD_BITS)) begin
                        done = 1'b1;
                        if (r_kind == dlft_pkg::KIND_SEND) begin
                            code = dlft_pkg::RES_OK;
                        end else if (r_kind == dlft_pkg::KIND_HALF) begin
                            code = (n_rx == REPLY_NOT_READY) ? dlft_pkg::RES_OK : err_code;
                        end else if (!r_status) begin
                            code = dlft_pkg::RES_OK;
                        end else if (n_rx == REPLY_NOT_READY && r_attempts != 8'd0) begin
                            // target not ready: repeat the frame
                            n_attempts = r_attempts - 8'd1;
                            n_tx       = r_frame;
                            done       = 1'b0;
                        end else begin
                            code = err_code;
                        end
                        n_pos = '0;
                        if (done) begin
                            n_kind = dlft_pkg::KIND_IDLE;
                        end
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            default: begin
                n_kind = dlft_pkg::KIND_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx       <= '0;
            r_rx       <= '0;
            r_frame    <= '0;
            r_pos      <= '0;
            r_attempts <= '0;
            r_kind     <= dlft_pkg::KIND_IDLE;
            r_status   <= 1'b0;
        end else if (i_step) begin
            r_tx       <= n_tx;
            r_rx       <= n_rx;
            r_frame    <= n_frame;
            r_pos      <= n_pos;
            r_attempts <= n_attempts;
            r_kind     <= n_kind;
            r_status   <= n_status;
        end
    end

    assign o_res.dout   = dout;
    assign o_res.busy   = (n_kind != dlft_pkg::KIND_IDLE);
    assign o_res.done   = done;
    assign o_res.code   = done ? code : dlft_pkg::RES_OK;
    assign o_rx_word    = n_rx;
    assign o_rx_status  = n_status;

endmodule

// ===== sv/dlft_checker.sv =====
// ----------------------------------------------------------------------------
// dlft_checker
// Port-level checks for the debug link frame transactor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlft_checker #(
    parameter int WORD_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic                 o_data_out_bit,
    input logic                 o_busy_res,
    input logic                 o_done_res,
    input logic [1:0]           o_result_code,
    input logic [WORD_BITS-1:0] o_rx_word,
    input logic                 o_rx_status
);

    logic [WORD_BITS+5:0] out_bus;
    logic                 idle_shown;

    assign out_bus    = {o_data_out_bit, o_busy_res, o_done_res, o_result_code,
                         o_rx_word, o_rx_status};
    assign idle_shown = o_valid && !o_busy_res && !o_done_res;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(out_bus))
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_valid && o_done_res, !o_busy_res)
    `ASSERT_IMPL(a_code_on_done, i_clk, i_rst_n, o_valid && !o_done_res, o_result_code == 2'd0)
    `ASSERT_IMPL(a_idle_line_low, i_clk, i_rst_n, idle_shown, !o_data_out_bit)

endmodule

bind debug_link_frame_transactor_unit dlft_checker #(.WORD_BITS(WORD_BITS)) u_dlft_checker (.*);

// ===== tb/debug_link_frame_transactor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// debug_link_frame_transactor_unit_tb
// Self-checking bench for the serial debug link master: feeds request and
// bit-tick transfers with random idle gaps and result stalls. It predicts
// every result transfer from its own frame model and compares field by field.
// ----------------------------------------------------------------------------
module debug_link_frame_transactor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlft_pkg::*;

    localparam int          WORD_BITS       = 16;
    localparam logic [15:0] CMD_NOP         = 16'h0000;
    localparam logic [15:0] REPLY_NOT_READY = 16'h0000;
    localparam logic [15:0] REPLY_BUS_ERROR = 16'h0001;
    localparam logic [15:0] REPLY_ILLEGAL   = 16'hFFFF;
    localparam logic [2:0]  REQ_UNKNOWN_LO  = 3'd5;
    localparam logic [2:0]  REQ_CODE_MAX    = 3'd7;
    localparam int          RANDOM_PHASES   = 5;
    localparam int          PHASE_TICKS     = 290;

    typedef struct packed {
        logic [2:0]  req;
        logic [15:0] cmd;
        logic        last;
        logic        din;
    } t_tick_item;

    typedef struct packed {
        logic        dout;
        logic        busy;
        logic        done;
        t_code       code;
        logic [15:0] rx_word;
        logic        rx_status;
    } t_link_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type    = '0;
    logic [15:0] i_cmd_word    = '0;
    logic        i_last_word   = 1'b0;
    logic        i_data_in_bit = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic        o_data_out_bit;
    logic        o_busy_res;
    logic        o_done_res;
    logic [1:0]  o_result_code;
    logic [15:0] o_rx_word;
    logic        o_rx_status;

    debug_link_frame_transactor_unit #(
        .WORD_BITS(WORD_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_cmd_word    (i_cmd_word),
        .i_last_word   (i_last_word),
        .i_data_in_bit (i_data_in_bit),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_out_bit(o_data_out_bit),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_result_code (o_result_code),
        .o_rx_word     (o_rx_word),
        .o_rx_status   (o_rx_status)
    );

    always #6 i_clk = ~i_clk;

    t_tick_item   tick_backlog[$];
    t_link_result pending_link_results[$];

    // link state mirrored by the predictor
    logic [7:0]  link_retry_limit = RETRY_RESET;
    t_kind       link_kind        = KIND_IDLE;
    logic [15:0] tx_shift         = '0;
    logic [15:0] rx_shift         = '0;
    logic [15:0] frame_word       = '0;
    logic [4:0]  bit_pos          = '0;
    logic [7:0]  attempts_left    = '0;
    logic        status_seen      = 1'b0;

    int retry_setting = RETRY_RESET;
    bit throttle      = 1'b1;
    int error_count;
    int ticks_planned;
    int results_checked;
    int retries_seen;
    int cfg_writes;
    int finish_count [4];

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            report_error($sformatf("result %0d: %s expected %h got %h",
                                   results_checked, name, want, got));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_kind kind_of_req(input logic [2:0] req);
        case (req)
            REQ_SEND:  return KIND_SEND;
            REQ_RECV:  return KIND_RECV;
            REQ_CHECK: return KIND_CHECK;
            REQ_HALF:  return KIND_HALF;
            default:   return KIND_IDLE;
        endcase
    endfunction

    function automatic t_code decode_reply(input logic [15:0] reply);
        if (reply == REPLY_BUS_ERROR) return RES_BUS_ERR;
        if (reply == REPLY_ILLEGAL) return RES_ILLEGAL;
        return RES_NO_CONN;
    endfunction

    // advance the link by one tick and queue the result it must produce
    task automatic predict_link_tick(input logic [2:0] req, input logic [15:0] cmd,
                                     input logic last, input logic din);
        t_link_result res;
        logic         frame_done;
        res = '0;
        if (link_kind == KIND_IDLE) begin
            if (kind_of_req(req) != KIND_IDLE) begin
                link_kind     = kind_of_req(req);
                frame_word    = (req == REQ_RECV && !last) ? CMD_NOP : cmd;
                tx_shift      = frame_word;
                bit_pos       = '0;
                attempts_left = link_retry_limit;
            end
        end else if (bit_pos == 0) begin
            status_seen = din;
            rx_shift    = '0;
            bit_pos     = 5'd1;
        end else begin
            res.dout = tx_shift[WORD_BITS-1];
            tx_shift = tx_shift << 1;
            rx_shift = {rx_shift[WORD_BITS-2:0], din};
            if (bit_pos >= WORD_BITS) begin
                frame_done = 1'b1;
                res.code   = RES_OK;
                if (link_kind == KIND_HALF) begin
                    if (rx_shift != REPLY_NOT_READY) res.code = decode_reply(rx_shift);
                end else if (link_kind != KIND_SEND && status_seen) begin
                    if (rx_shift == REPLY_NOT_READY && attempts_left != 0) begin
                        // target not ready: replay the same frame
                        attempts_left--;
                        tx_shift   = frame_word;
                        bit_pos    = '0;
                        frame_done = 1'b0;
                        retries_seen++;
                    end else begin
                        res.code = decode_reply(rx_shift);
                    end
                end
                if (frame_done) begin
                    res.done  = 1'b1;
                    link_kind = KIND_IDLE;
                    bit_pos   = '0;
                    finish_count[res.code]++;
                end
            end else begin
                bit_pos++;
            end
        end
        res.busy      = (link_kind != KIND_IDLE);
        res.rx_word   = rx_shift;
        res.rx_status = status_seen;
        pending_link_results.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic push_tick(input logic [2:0] req, input logic [15:0] cmd,
                             input logic last, input logic din);
        t_tick_item item;
        item.req  = req;
        item.cmd  = cmd;
        item.last = last;
        item.din  = din;
        tick_backlog.push_back(item);
        ticks_planned++;
    endtask

    task automatic push_idle(input int n);
        repeat (n) begin
            if ($urandom_range(0, 1))
                push_tick(REQ_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
            else
                push_tick(3'($urandom_range(REQ_UNKNOWN_LO, REQ_CODE_MAX)), 16'($urandom),
                          1'($urandom), 1'($urandom));
        end
    endtask

    // start bit carries the status, then the reply most significant bit first;
    // stray request codes on the bit ticks must be ignored
    task automatic push_frame(input logic status, input logic [15:0] reply,
                              input logic stray);
        push_tick(stray ? 3'($urandom_range(REQ_SEND, REQ_CODE_MAX)) : REQ_TICK,
                  16'($urandom), 1'($urandom), status);
        for (int i = WORD_BITS - 1; i >= 0; i--)
            push_tick(stray ? 3'($urandom_range(REQ_SEND, REQ_CODE_MAX)) : REQ_TICK,
                      16'($urandom), 1'($urandom), reply[i]);
    endtask

    task automatic push_transaction(input logic [2:0] req, input logic [15:0] cmd,
                                    input logic last, input int not_ready_frames,
                                    input logic status, input logic [15:0] reply,
                                    input logic stray);
        push_tick(req, cmd, last, 1'($urandom));
        if (req == REQ_RECV || req == REQ_CHECK) begin
            for (int f = 0; f < not_ready_frames && f <= retry_setting; f++)
                push_frame(1'b1, REPLY_NOT_READY, stray);
            if (not_ready_frames <= retry_setting) push_frame(status, reply, stray);
        end else begin
            push_frame(status, reply, stray);
        end
    endtask

    task automatic push_random_transaction();
        logic [2:0]  req;
        logic [15:0] reply;
        logic        status;
        int          nr;
        int          r;
        req    = 3'($urandom_range(REQ_SEND, REQ_HALF));
        status = ($urandom_range(0, 3) != 0);
        r      = $urandom_range(0, 4);
        case (r)
            0:       reply = REPLY_NOT_READY;
            1:       reply = REPLY_BUS_ERROR;
            2:       reply = REPLY_ILLEGAL;
            default: reply = 16'($urandom);
        endcase
        // a final not-ready with status set would retry again: clear status
        if ((req == REQ_RECV || req == REQ_CHECK) && status && reply == REPLY_NOT_READY)
            status = 1'b0;
        r = $urandom_range(0, 9);
        if (r < 6)
            nr = 0;
        else if (r < 9)
            nr = $urandom_range(1, 3);
        else
            nr = (retry_setting <= 3) ? retry_setting + 1 : $urandom_range(1, 5);
        push_transaction(req, 16'($urandom), 1'($urandom), nr, status, reply,
                         ($urandom_range(0, 9) == 0));
        if ($urandom_range(0, 3) == 0) push_idle($urandom_range(1, 2));
    endtask

    task automatic write_retry_limit(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid      <= 1'b0;
        link_retry_limit  = value;
        retry_setting     = value;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (tick_backlog.size() != 0 || i_valid || pending_link_results.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        t_tick_item item;
        int         gap_left;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready)
                predict_link_tick(i_req_type, i_cmd_word, i_last_word, i_data_in_bit);
            // hold the payload until the transfer completes
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (tick_backlog.size() != 0) begin
                    item = tick_backlog.pop_front();
                    i_valid       <= 1'b1;
                    i_req_type    <= item.req;
                    i_cmd_word    <= item.cmd;
                    i_last_word   <= item.last;
                    i_data_in_bit <= item.din;
                    gap_left = throttle ? pick_gap() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : collect
        t_link_result want;
        int           stall_left;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_link_results.size() == 0) begin
                    report_error($sformatf("result transfer with no tick pending, rx_word %h",
                                           o_rx_word));
                end else begin
                    want = pending_link_results.pop_front();
                    check_field("data_out_bit", want.dout, o_data_out_bit);
                    check_field("busy_res", want.busy, o_busy_res);
                    check_field("done_res", want.done, o_done_res);
                    check_field("result_code", want.code, o_result_code);
                    check_field("rx_word", want.rx_word, o_rx_word);
                    check_field("rx_status", want.rx_status, o_rx_status);
                    results_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = throttle ? pick_gap() : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int         phase_start;
        int         sel;
        logic [7:0] setting;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every request kind and reply decode at the reset limit
        push_idle(2);
        push_transaction(REQ_SEND, 16'hFFFF, 1'b0, 0, 1'b1, REPLY_ILLEGAL, 1'b0);
        push_transaction(REQ_SEND, 16'h0000, 1'b1, 0, 1'b0, REPLY_NOT_READY, 1'b1);
        push_transaction(REQ_RECV, 16'hA5A5, 1'b0, 0, 1'b0, 16'h1234, 1'b0);
        push_transaction(REQ_RECV, 16'h8001, 1'b1, 2, 1'b1, REPLY_BUS_ERROR, 1'b0);
        push_transaction(REQ_CHECK, 16'h7FFE, 1'b0, 0, 1'b1, REPLY_ILLEGAL, 1'b0);
        push_transaction(REQ_CHECK, 16'h4C3B, 1'b1, 1, 1'b1, 16'h5A5A, 1'b0);
        push_transaction(REQ_HALF, 16'h0F0F, 1'b0, 0, 1'b1, REPLY_NOT_READY, 1'b0);
        push_transaction(REQ_HALF, 16'hF0F0, 1'b0, 0, 1'b1, REPLY_BUS_ERROR, 1'b0);
        push_transaction(REQ_HALF, 16'h3C3C, 1'b0, 0, 1'b0, REPLY_ILLEGAL, 1'b0);
        push_transaction(REQ_HALF, 16'hC3C3, 1'b0, 0, 1'b1, 16'h1357, 1'b0);
        push_transaction(REQ_RECV, 16'h1111, 1'b1, 0, 1'b0, REPLY_NOT_READY, 1'b0);
        for (int c = REQ_UNKNOWN_LO; c <= REQ_CODE_MAX; c++)
            push_tick(3'(c), 16'($urandom), 1'b1, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // pause the sender until every result has been collected
            wait_drained();
            case (p)
                0:       setting = 8'd0;
                1:       setting = 8'd255;
                2:       setting = 8'd1;
                3:       setting = 8'($urandom_range(4, 254));
                default: setting = 8'd3;
            endcase
            throttle = (p != 2);
            write_retry_limit(setting);
            if (p == 0) begin
                // no retries allowed: a single not-ready frame ends the transfer
                push_transaction(REQ_RECV, 16'($urandom), 1'b1, 1, 1'b1, REPLY_NOT_READY, 1'b0);
                push_transaction(REQ_CHECK, 16'($urandom), 1'b0, 0, 1'b1, REPLY_NOT_READY,
                                 1'b0);
            end
            phase_start = ticks_planned;
            while (ticks_planned - phase_start < PHASE_TICKS) begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    push_random_transaction();
                else if (sel < 90)
                    repeat ($urandom_range(1, 20))
                        push_tick(3'($urandom_range(REQ_TICK, REQ_CODE_MAX)), 16'($urandom),
                                  1'($urandom), 1'($urandom));
                else
                    push_idle($urandom_range(1, 4));
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Summary: %0d ticks checked over %0d retry-limit settings, %0d frame retries",
                 results_checked, cfg_writes + 1, retries_seen);
        $display("Summary: finished transfers ok %0d, bus error %0d, illegal %0d, no link %0d",
                 finish_count[RES_OK], finish_count[RES_BUS_ERR],
                 finish_count[RES_ILLEGAL], finish_count[RES_NO_CONN]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Timeout: %0d results still outstanding", pending_link_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== debug_link_frame_transactor_unit.f =====
+incdir+sv
sv/dlft_pkg.sv
sv/dlft_engine.sv
sv/debug_link_frame_transactor_unit.sv
sv/dlft_checker.sv
tb/debug_link_frame_transactor_unit_tb.sv
